// ----- rtl/core/kvc_pkg.sv -----
// Shared types and constants for the LRU key/value cache.
// No dependencies; imported by kvc_decide, kvc_store and lru_key_value_cache.
package kvc_pkg;

    // Request kinds carried in the slave-side tuser
    localparam logic [1:0] MODE_PEEK   = 2'd0;
    localparam logic [1:0] MODE_LOOKUP = 2'd1;
    localparam logic [1:0] MODE_INSERT = 2'd2;

    // Port field widths
    localparam int MODE_W      = 2;
    localparam int KEY_W       = 64;
    localparam int VALUE_W     = 32;
    localparam int IN_TDATA_W  = KEY_W + VALUE_W;
    localparam int OUT_TDATA_W = 2 * VALUE_W;
    localparam int OUT_TUSER_W = 3;

    // Per-request decision handed from kvc_decide to kvc_store
    typedef struct packed {
        logic hit;      // peek or lookup found the key
        logic touch;    // lookup hit: move entry to most recent
        logic insert;   // insert of a new key is written
        logic evict;    // insert displaces the least recent entry
        logic dup;      // insert key already present, dropped
    } kvc_ctl_t;

endpackage

// ----- rtl/core/lru_key_value_cache.sv -----
// Top level of the fully associative LRU key/value cache.
// Depends on kvc_pkg, kvc_decide and kvc_store.

// Fully associative key/value cache of ENTRIES entries with least-recently-
// used replacement. Each slave transfer carries one request (tuser = mode:
// 0 peek, 1 lookup, 2 insert; tdata = key, value) and yields exactly one
// master transfer. A request is taken into an input register, where the key
// is compared against every entry in parallel; when the output register is
// free or drains, the recency ranks are updated and the result is loaded
// into the output register, from which it is offered on the master side. One
// request is taken every cycle as long as the master side keeps up. The
// rate is set by that combinational compare and rank update across all
// entries. Rank 0 is most recent; a lookup hit moves its entry to rank 0, a
// peek leaves ranks alone. An insert goes to the lowest free entry or, when
// the store is full, over the least recent entry whose value is returned as
// evicted_value. An insert of a key already present is flagged as duplicate
// and dropped. Mode 3 yields an all-zero result. Only the low KEY_BITS key
// bits and low VALUE_BITS value bits are kept. All entries are invalid
// after reset; there is no clearing pass.
module lru_key_value_cache #(
    parameter int ENTRIES    = 16,
    parameter int KEY_BITS   = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [kvc_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // key[63:0], value[95:64]
    input  logic [kvc_pkg::MODE_W-1:0]       s_axis_tuser,  // mode[1:0]
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [kvc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,  // read_value[31:0], evicted_value[63:32]
    output logic [kvc_pkg::OUT_TUSER_W-1:0]  m_axis_tuser   // hit[0], evicted[1], duplicate[2]
);
    import kvc_pkg::*;

    // Input register
    logic                  in_valid_reg;
    logic                  in_valid_next;
    logic [MODE_W-1:0]     mode_reg;
    logic [KEY_W-1:0]      key_reg;
    logic [VALUE_W-1:0]    value_reg;

    // Output register
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [VALUE_W-1:0]    read_value_reg;
    logic [VALUE_W-1:0]    evicted_value_reg;
    logic                  hit_reg;
    logic                  evicted_reg;
    logic                  dup_reg;

    logic                  s_accept;
    logic                  advance;
    logic [63:0]           value_wide;

    kvc_ctl_t              ctl;
    logic [ENTRIES-1:0]    hit_vec;
    logic [ENTRIES-1:0]    free_vec;
    logic [ENTRIES-1:0]    victim_vec;
    logic [ENTRIES-1:0]    write_vec;
    logic [ENTRIES-1:0]    sel_vec;
    logic                  full;
    logic [VALUE_BITS-1:0] sel_value;
    logic [VALUE_W-1:0]    sel_value_out;

    // The request moves on whenever the output register is free or drains
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    assign value_wide    = 64'(value_reg);
    assign sel_value_out = VALUE_W'(sel_value);

    kvc_store #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_key    (key_reg[KEY_BITS-1:0]),
        .req_value  (value_wide[VALUE_BITS-1:0]),
        .ctl        (ctl),
        .write_vec  (write_vec),
        .sel_vec    (sel_vec),
        .hit_vec    (hit_vec),
        .free_vec   (free_vec),
        .victim_vec (victim_vec),
        .full       (full),
        .sel_value  (sel_value)
    );

    kvc_decide #(
        .ENTRIES    (ENTRIES)
    ) u_decide (
        .mode       (mode_reg),
        .req_valid  (advance),
        .hit_vec    (hit_vec),
        .free_vec   (free_vec),
        .victim_vec (victim_vec),
        .full       (full),
        .ctl        (ctl),
        .write_vec  (write_vec),
        .sel_vec    (sel_vec)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_accept)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            mode_reg  <= s_axis_tuser;
            key_reg   <= s_axis_tdata[KEY_W-1:0];
            value_reg <= s_axis_tdata[IN_TDATA_W-1:KEY_W];
        end
        if (advance)
        begin
            hit_reg           <= ctl.hit;
            evicted_reg       <= ctl.evict;
            dup_reg           <= ctl.dup;
            read_value_reg    <= ctl.hit   ? sel_value_out : '0;
            evicted_value_reg <= ctl.evict ? sel_value_out : '0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {evicted_value_reg, read_value_reg};
    assign m_axis_tuser  = {dup_reg, evicted_reg, hit_reg};

`ifndef SYNTHESIS
    // A result reports at most one outcome
    assert property (@(posedge clk) disable iff (!rst_n)
                     m_axis_tvalid |-> $onehot0({hit_reg, evicted_reg, dup_reg}))
        else $error("lru_key_value_cache: conflicting result flags");

    // Value fields are zero unless their flag is set
    assert property (@(posedge clk) disable iff (!rst_n)
                     m_axis_tvalid |-> ((hit_reg || read_value_reg == '0) &&
                                        (evicted_reg || evicted_value_reg == '0)))
        else $error("lru_key_value_cache: value reported without its flag");

    // Eviction happens only from a full store
    assert property (@(posedge clk) disable iff (!rst_n) ctl.evict |-> full)
        else $error("lru_key_value_cache: eviction from a store with free entries");
`endif

endmodule

// ----- rtl/core/kvc_decide.sv -----
// Request decode: turns the match results of the store into one decision.
// Depends on kvc_pkg.
module kvc_decide #(
    parameter int ENTRIES = 16
) (
    input  logic [1:0]         mode,
    input  logic               req_valid,
    input  logic [ENTRIES-1:0] hit_vec,
    input  logic [ENTRIES-1:0] free_vec,
    input  logic [ENTRIES-1:0] victim_vec,
    input  logic               full,
    output kvc_pkg::kvc_ctl_t  ctl,
    output logic [ENTRIES-1:0] write_vec,
    output logic [ENTRIES-1:0] sel_vec
);
    import kvc_pkg::*;

    logic any_hit;
    logic is_read;
    logic is_insert;

    always_comb
    begin
        any_hit   = |hit_vec;
        is_read   = 1'b0;
        is_insert = 1'b0;
        case (mode)
            MODE_PEEK:   is_read   = 1'b1;
            MODE_LOOKUP: is_read   = 1'b1;
            MODE_INSERT: is_insert = 1'b1;
            default:     ;
        endcase

        ctl.hit    = req_valid & is_read & any_hit;
        ctl.touch  = req_valid & (mode == MODE_LOOKUP) & any_hit;
        ctl.dup    = req_valid & is_insert & any_hit;
        ctl.insert = req_valid & is_insert & ~any_hit;
        ctl.evict  = ctl.insert & full;

        // New pair goes to the lowest free entry, or over the victim when full
        write_vec = ctl.insert ? (full ? victim_vec : free_vec) : '0;
        // One read port: victim value on insert, hit value otherwise
        sel_vec   = is_insert ? victim_vec : hit_vec;
    end

endmodule

// ----- rtl/core/kvc_store.sv -----
// Entry array of the cache: valid bits, keys, values and recency ranks,
// parallel key match, victim pick and the rank update. Depends on kvc_pkg.
module kvc_store #(
    parameter int ENTRIES    = 16,
    parameter int KEY_BITS   = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [KEY_BITS-1:0]   req_key,
    input  logic [VALUE_BITS-1:0] req_value,
    input  kvc_pkg::kvc_ctl_t     ctl,
    input  logic [ENTRIES-1:0]    write_vec,
    input  logic [ENTRIES-1:0]    sel_vec,
    output logic [ENTRIES-1:0]    hit_vec,
    output logic [ENTRIES-1:0]    free_vec,
    output logic [ENTRIES-1:0]    victim_vec,
    output logic                  full,
    output logic [VALUE_BITS-1:0] sel_value
);
    import kvc_pkg::*;

    localparam int RANK_W = $clog2(ENTRIES);
    localparam logic [RANK_W-1:0] RANK_LAST = RANK_W'(ENTRIES - 1);

    logic [ENTRIES-1:0]    entry_valid_reg;
    logic [ENTRIES-1:0]    entry_valid_next;
    logic [KEY_BITS-1:0]   entry_key_reg   [ENTRIES];
    logic [VALUE_BITS-1:0] entry_value_reg [ENTRIES];
    logic [RANK_W-1:0]     entry_rank_reg  [ENTRIES];
    logic [RANK_W-1:0]     entry_rank_next [ENTRIES];
    logic [RANK_W-1:0]     hit_rank;
    logic [ENTRIES-1:0]    invalid_vec;

    // Match, free and victim vectors; AND-OR reads of the selected entry
    always_comb
    begin
        invalid_vec = ~entry_valid_reg;
        free_vec    = invalid_vec & ~(invalid_vec - ENTRIES'(1));
        full        = &entry_valid_reg;
        hit_rank    = '0;
        sel_value   = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            hit_vec[i]    = entry_valid_reg[i] && (entry_key_reg[i] == req_key);
            victim_vec[i] = entry_valid_reg[i] && (entry_rank_reg[i] == RANK_LAST);
            hit_rank      = hit_rank  | (entry_rank_reg[i]  & {RANK_W{hit_vec[i]}});
            sel_value     = sel_value | (entry_value_reg[i] & {VALUE_BITS{sel_vec[i]}});
        end
    end

    // Recency: 0 is most recent; entries younger than the moved one age by one
    always_comb
    begin
        entry_valid_next = entry_valid_reg | write_vec;
        for (int i = 0; i < ENTRIES; i++)
        begin
            entry_rank_next[i] = entry_rank_reg[i];
            if (ctl.insert)
            begin
                if (write_vec[i])
                    entry_rank_next[i] = '0;
                else if (entry_valid_reg[i])
                    entry_rank_next[i] = entry_rank_reg[i] + RANK_W'(1);
            end
            else if (ctl.touch)
            begin
                if (hit_vec[i])
                    entry_rank_next[i] = '0;
                else if (entry_valid_reg[i] && (entry_rank_reg[i] < hit_rank))
                    entry_rank_next[i] = entry_rank_reg[i] + RANK_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            entry_valid_reg <= '0;
        else
            entry_valid_reg <= entry_valid_next;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            entry_rank_reg[i] <= entry_rank_next[i];
            if (write_vec[i])
            begin
                entry_key_reg[i]   <= req_key;
                entry_value_reg[i] <= req_value;
            end
        end
    end

`ifndef SYNTHESIS
    // Keys of valid entries stay distinct
    assert property (@(posedge clk) disable iff (!rst_n) $onehot0(hit_vec))
        else $error("kvc_store: key present in more than one entry");

    // Ranks of a full store are a permutation, so exactly one victim
    assert property (@(posedge clk) disable iff (!rst_n) full |-> $onehot(victim_vec))
        else $error("kvc_store: full store without a unique least recent entry");

    // An insert writes exactly one entry, which is valid afterwards
    assert property (@(posedge clk) disable iff (!rst_n)
                     ctl.insert |-> $onehot(write_vec))
        else $error("kvc_store: insert without a single target entry");
`endif

endmodule

// ----- tb/sv/tb_lru_key_value_cache.sv -----
// Self-checking testbench for lru_key_value_cache: directed then random requests.
// Holds its own LRU cache predictor; depends on kvc_pkg and the cache RTL only.
module tb_lru_key_value_cache;
    timeunit 1ns;
    timeprecision 1ps;

    import kvc_pkg::*;

    localparam int         CACHE_DEPTH = 16;
    // Mode three is not a real request; the block answers with an all-zero result.
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int         RANDOM_PER_PHASE = 175;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
        logic [1:0]         phase;   // idle pattern in force while this request is sent
    } cache_req_t;

    typedef struct packed {
        logic               hit;
        logic [VALUE_W-1:0] read_value;
        logic               evicted;
        logic [VALUE_W-1:0] evicted_value;
        logic               dup;
    } cache_resp_t;

    // Idle percentages per phase: receiver-heavy stalls, then sender-heavy, then none.
    int tx_idle_pct [3] = '{27, 65, 0};
    int rx_idle_pct [3] = '{65, 27, 0};

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic [MODE_W-1:0]      s_axis_tuser  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [OUT_TUSER_W-1:0] m_axis_tuser;

    cache_req_t  pending_reqs[$];       // requests not yet offered to the block
    cache_resp_t expected_results[$];   // predicted results, oldest first
    cache_req_t  in_flight;             // request currently held on the slave side
    logic [1:0]  idle_phase = 2'd0;
    int          mismatches = 0;

    // Predictor state: mirror of the cache contents and recency ranks
    logic               line_valid [CACHE_DEPTH];
    logic [KEY_W-1:0]   line_key   [CACHE_DEPTH];
    logic [VALUE_W-1:0] line_value [CACHE_DEPTH];
    int                 line_rank  [CACHE_DEPTH];   // 0 = most recent
    int                 line_count = 0;

    // Stimulus-side memory of the last 40 keys queued for insert
    logic [KEY_W-1:0] known_keys[$];
    logic [1:0]       gen_phase = 2'd0;

    lru_key_value_cache dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // key[63:0], value[95:64]
        .s_axis_tuser  (s_axis_tuser),   // mode[1:0]
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // read_value[31:0], evicted_value[63:32]
        .m_axis_tuser  (m_axis_tuser)    // hit[0], evicted[1], duplicate[2]
    );

    always #4 clk = ~clk;

    // Apply one request to the predicted cache and return the result it should give.
    function automatic cache_resp_t cache_access(input cache_req_t r);
        cache_resp_t res;
        int          slot;
        int          worst;
        int          i;
        res  = '0;
        slot = -1;
        for (i = 0; i < CACHE_DEPTH; i++)
        begin
            if (slot < 0 && line_valid[i] && line_key[i] == r.key)
                slot = i;
        end
        if (r.mode == MODE_PEEK || r.mode == MODE_LOOKUP)
        begin
            if (slot >= 0)
            begin
                res.hit        = 1'b1;
                res.read_value = line_value[slot];
                if (r.mode == MODE_LOOKUP)
                begin
                    // everything fresher than the hit entry ages by one
                    for (i = 0; i < CACHE_DEPTH; i++)
                    begin
                        if (line_valid[i] && line_rank[i] < line_rank[slot])
                            line_rank[i]++;
                    end
                    line_rank[slot] = 0;
                end
            end
        end
        else if (r.mode == MODE_INSERT)
        begin
            if (slot >= 0)
                res.dup = 1'b1;
            else
            begin
                // lowest free line first
                for (i = CACHE_DEPTH - 1; i >= 0; i--)
                begin
                    if (!line_valid[i])
                        slot = i;
                end
                if (slot < 0)
                begin
                    // full: victim is the stalest line
                    worst = 0;
                    slot  = 0;
                    for (i = 0; i < CACHE_DEPTH; i++)
                    begin
                        if (line_rank[i] >= worst)
                        begin
                            worst = line_rank[i];
                            slot  = i;
                        end
                    end
                    res.evicted       = 1'b1;
                    res.evicted_value = line_value[slot];
                    line_valid[slot]  = 1'b0;
                    line_count--;
                end
                for (i = 0; i < CACHE_DEPTH; i++)
                begin
                    if (line_valid[i])
                        line_rank[i]++;
                end
                line_valid[slot] = 1'b1;
                line_key[slot]   = r.key;
                line_value[slot] = r.value;
                line_rank[slot]  = 0;
                line_count++;
            end
        end
        return res;
    endfunction

    function automatic logic [KEY_W-1:0] fresh_key();
        return {$urandom, $urandom};
    endfunction

    task automatic queue_req(input logic [1:0] mode, input logic [KEY_W-1:0] key,
                             input logic [VALUE_W-1:0] value);
        cache_req_t r;
        r.mode  = mode;
        r.key   = key;
        r.value = value;
        r.phase = gen_phase;
        pending_reqs.push_back(r);
        if (mode == MODE_INSERT)
        begin
            known_keys.push_back(key);
            if (known_keys.size() > 40)
                void'(known_keys.pop_front());
        end
    endtask

    // Key from the recently inserted set, mostly still resident
    function automatic logic [KEY_W-1:0] recent_key();
        int span;
        span = (known_keys.size() < 20) ? known_keys.size() : 20;
        return known_keys[known_keys.size() - 1 - $urandom_range(span - 1)];
    endfunction

    task automatic check_field(input string name, input logic [VALUE_W-1:0] want,
                               input logic [VALUE_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Driver: offers queued requests, predicts each one at its accepting edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                expected_results.push_back(cache_access(in_flight));
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_reqs.size() != 0 &&
                    $urandom_range(99) >= tx_idle_pct[pending_reqs[0].phase])
                begin
                    in_flight     = pending_reqs.pop_front();
                    idle_phase   <= in_flight.phase;
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {in_flight.value, in_flight.key};
                    s_axis_tuser  <= in_flight.mode;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: random backpressure, each result checked against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        cache_resp_t got;
        cache_resp_t want;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.read_value    = m_axis_tdata[VALUE_W-1:0];
                got.evicted_value = m_axis_tdata[2*VALUE_W-1:VALUE_W];
                got.hit           = m_axis_tuser[0];
                got.evicted       = m_axis_tuser[1];
                got.dup           = m_axis_tuser[2];
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, got);
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("hit", want.hit, got.hit);
                    check_field("read_value", want.read_value, got.read_value);
                    check_field("evicted", want.evicted, got.evicted);
                    check_field("evicted_value", want.evicted_value, got.evicted_value);
                    check_field("duplicate", want.dup, got.dup);
                end
            end
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct[idle_phase]);
        end
    end

    initial
    begin
        int i;
        int p;
        int pick;
        for (i = 0; i < CACHE_DEPTH; i++)
        begin
            line_valid[i] = 1'b0;
            line_key[i]   = '0;
            line_value[i] = '0;
            line_rank[i]  = 0;
        end

        // Directed: empty-cache misses, extremes of key and value, duplicate,
        // unused mode, fill to capacity, evictions in LRU order, miss after eviction.
        queue_req(MODE_PEEK,   '0, $urandom);
        queue_req(MODE_LOOKUP, '1, $urandom);
        queue_req(MODE_INSERT, '0, '0);
        queue_req(MODE_INSERT, '1, '1);
        queue_req(MODE_PEEK,   '0, $urandom);
        queue_req(MODE_LOOKUP, '1, $urandom);    // all-ones key becomes most recent
        queue_req(MODE_INSERT, '0, '1);          // already present
        queue_req(MODE_UNUSED, '1, '1);
        for (i = 1; i <= 14; i++)
            queue_req(MODE_INSERT, 64'h1111_1111_1111_1111 * i, $urandom);
        queue_req(MODE_INSERT, fresh_key(), $urandom);   // full: key 0 goes
        queue_req(MODE_LOOKUP, 64'h1111_1111_1111_1111, $urandom);
        queue_req(MODE_INSERT, fresh_key(), $urandom);   // all-ones key goes
        queue_req(MODE_PEEK,   '0, $urandom);

        // Random: mostly inserts of new keys and hits on recent ones, with
        // stale keys, unknown keys, duplicates and the unused mode mixed in.
        for (p = 0; p < 3; p++)
        begin
            gen_phase = p[1:0];
            for (i = 0; i < RANDOM_PER_PHASE; i++)
            begin
                pick = $urandom_range(99);
                if (pick < 3)
                    queue_req(MODE_UNUSED, fresh_key(), $urandom);
                else if (pick < 35)
                    queue_req(MODE_INSERT,
                              ($urandom_range(99) < 85) ? fresh_key() : recent_key(),
                              $urandom);
                else
                    queue_req(($urandom_range(99) < 40) ? MODE_PEEK : MODE_LOOKUP,
                              ($urandom_range(99) < 80) ? recent_key() : fresh_key(),
                              $urandom);
            end
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
            @(posedge clk);
        // pipeline of input and output register; anything extra would show up well within this
        repeat (10) @(posedge clk);
        if (mismatches == 0 && pending_reqs.size() == 0 && expected_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run
    initial
    begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
